// File: rtl/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg: sorted table with binary search, shared definitions
// Field widths, status codes, microcode step codes and the control store.
// ----------------------------------------------------------------------------
package stbs_pkg;

	localparam int ENTRIES_DEF = 128;
	localparam int NAME_W      = 64;
	localparam int KEY_W       = 50;
	localparam int ENTRY_W     = NAME_W + KEY_W;
	localparam int STATUS_W    = 3;

	localparam logic [STATUS_W-1:0] ST_ADDED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FOUND = 3'd1;
	localparam logic [STATUS_W-1:0] ST_MISS  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	// step codes
	localparam int PC_W = 3;
	localparam logic [PC_W-1:0] S_IDLE    = 3'd0;
	localparam logic [PC_W-1:0] S_SORT_I  = 3'd1;
	localparam logic [PC_W-1:0] S_LOAD    = 3'd2;
	localparam logic [PC_W-1:0] S_CMP     = 3'd3;
	localparam logic [PC_W-1:0] S_WB      = 3'd4;
	localparam logic [PC_W-1:0] S_BS_INIT = 3'd5;
	localparam logic [PC_W-1:0] S_BS_TEST = 3'd6;
	localparam logic [PC_W-1:0] S_BS_CMP  = 3'd7;

	// datapath operations
	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_ACCEPT   = 4'd1;
	localparam logic [3:0] OP_SORT_I   = 4'd2;
	localparam logic [3:0] OP_LOAD     = 4'd3;
	localparam logic [3:0] OP_SORT_CMP = 4'd4;
	localparam logic [3:0] OP_SORT_WB  = 4'd5;
	localparam logic [3:0] OP_BS_INIT  = 4'd6;
	localparam logic [3:0] OP_BS_TEST  = 4'd7;
	localparam logic [3:0] OP_BS_CMP   = 4'd8;

	// read address sources
	localparam logic [2:0] RD_NONE = 3'd0;
	localparam logic [2:0] RD_I    = 3'd1;
	localparam logic [2:0] RD_J    = 3'd2;
	localparam logic [2:0] RD_JN   = 3'd3;
	localparam logic [2:0] RD_MID  = 3'd4;

	// write sources
	localparam logic [1:0] WR_NONE   = 2'd0;
	localparam logic [1:0] WR_APPEND = 2'd1;
	localparam logic [1:0] WR_SWAP   = 2'd2;
	localparam logic [1:0] WR_I      = 2'd3;

	// jump conditions
	localparam logic [2:0] JC_NEVER     = 3'd0;
	localparam logic [2:0] JC_ALWAYS    = 3'd1;
	localparam logic [2:0] JC_SRCH_GO   = 3'd2;
	localparam logic [2:0] JC_SORT_DONE = 3'd3;
	localparam logic [2:0] JC_J_MORE    = 3'd4;
	localparam logic [2:0] JC_BS_OPEN   = 3'd5;
	localparam logic [2:0] JC_HIT       = 3'd6;

	typedef struct packed {
		logic [3:0]      op;
		logic [2:0]      rd;
		logic [1:0]      wr;
		logic [2:0]      cond;
		logic [PC_W-1:0] tgt_t;
		logic [PC_W-1:0] tgt_f;
		logic            hold_out;
	} ctrl_t;

	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t cw;
		cw = '{OP_NONE, RD_NONE, WR_NONE, JC_ALWAYS, S_IDLE, S_IDLE, 1'b0};
		unique case (pc)
			S_IDLE:    cw = '{OP_ACCEPT,   RD_NONE, WR_APPEND, JC_SRCH_GO,
				S_SORT_I, S_IDLE, 1'b0};
			S_SORT_I:  cw = '{OP_SORT_I,   RD_I,    WR_NONE,   JC_SORT_DONE,
				S_BS_INIT, S_LOAD, 1'b0};
			S_LOAD:    cw = '{OP_LOAD,     RD_J,    WR_NONE,   JC_ALWAYS,
				S_CMP, S_CMP, 1'b0};
			S_CMP:     cw = '{OP_SORT_CMP, RD_JN,   WR_SWAP,   JC_J_MORE,
				S_CMP, S_WB, 1'b0};
			S_WB:      cw = '{OP_SORT_WB,  RD_NONE, WR_I,      JC_ALWAYS,
				S_SORT_I, S_SORT_I, 1'b0};
			S_BS_INIT: cw = '{OP_BS_INIT,  RD_NONE, WR_NONE,   JC_ALWAYS,
				S_BS_TEST, S_BS_TEST, 1'b0};
			S_BS_TEST: cw = '{OP_BS_TEST,  RD_MID,  WR_NONE,   JC_BS_OPEN,
				S_BS_CMP, S_IDLE, 1'b1};
			S_BS_CMP:  cw = '{OP_BS_CMP,   RD_NONE, WR_NONE,   JC_HIT,
				S_IDLE, S_BS_TEST, 1'b1};
			default: ;
		endcase
		return cw;
	endfunction

endpackage

// File: rtl/stbs_ram.sv
// ----------------------------------------------------------------------------
// stbs_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/sorted_table_binary_search_top.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top: table of tagged keys, sort then search
// Append stores an entry; search exchange-sorts the table in place by key,
// then runs a binary search. Microcoded step sequencer over one RAM.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------
//  in      | in_valid/in_stall  | req_type, name_tag, number_key
//  out     | out_valid/out_stall| status, found_name, found_number
//
// Append, full and empty: result registered in the cycle after the item is accepted.
// Search on n entries: exchange sort, then binary search; one key compare per cycle
// through the single RAM read port sets the sort time.
// No clearing pass after reset; only entries below the count are used.
// A result waiting under out_stall holds off new items and the search probe steps.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top #(
	parameter int ENTRIES = stbs_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [stbs_pkg::NAME_W-1:0]   name_tag,
	input  logic [stbs_pkg::KEY_W-1:0]    number_key,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [stbs_pkg::STATUS_W-1:0] status,
	output logic [stbs_pkg::NAME_W-1:0]   found_name,
	output logic [stbs_pkg::KEY_W-1:0]    found_number
);

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	stbs_pkg::ctrl_t cw;

	logic [stbs_pkg::PC_W-1:0]     pc_q, pc_d;
	logic [CW-1:0]                 count_q, lo_q, hip1_q;
	logic [AW-1:0]                 i_q, j_q, mid_q, mid_c;
	logic [CW:0]                   mid_sum;
	logic [stbs_pkg::KEY_W-1:0]    key_q, hold_key_q, rd_key;
	logic [stbs_pkg::NAME_W-1:0]   hold_name_q, rd_name;
	logic                          out_valid_q;
	logic [stbs_pkg::STATUS_W-1:0] status_q;
	logic [stbs_pkg::NAME_W-1:0]   fname_q;
	logic [stbs_pkg::KEY_W-1:0]    fnum_q;

	logic                          out_busy, advance, in_fire, full, cond;
	logic                          i_done, j_more, bs_open, swap, hit, less;
	logic                          out_load;
	logic                          wr_en, rd_en;
	logic [AW-1:0]                 wr_addr, rd_addr;
	logic [stbs_pkg::ENTRY_W-1:0]  wr_data, rd_data;

	stbs_ram #(
		.WIDTH(stbs_pkg::ENTRY_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		cw       = stbs_pkg::ucode(pc_q);
		out_busy = out_valid_q && out_stall;
		advance  = !(cw.hold_out && out_busy);
		in_stall = (pc_q != stbs_pkg::S_IDLE) || out_busy;
		in_fire  = in_valid && !in_stall;
		full     = (count_q == CW'(ENTRIES));

		rd_key  = rd_data[stbs_pkg::KEY_W-1:0];
		rd_name = rd_data[stbs_pkg::ENTRY_W-1:stbs_pkg::KEY_W];

		i_done  = (CW'(i_q) + CW'(1)) >= count_q;
		j_more  = (CW'(j_q) + CW'(1)) < count_q;
		bs_open = lo_q < hip1_q;
		mid_sum = (CW+1)'(lo_q) + (CW+1)'(hip1_q) - (CW+1)'(1);
		mid_c   = AW'(mid_sum >> 1);
		swap    = hold_key_q > rd_key;
		hit     = rd_key == key_q;
		less    = rd_key < key_q;

		out_load = ((cw.op == stbs_pkg::OP_ACCEPT) && in_fire
				&& ((req_type == stbs_pkg::REQ_APPEND) || (count_q == '0)))
			|| ((cw.op == stbs_pkg::OP_BS_TEST) && advance && !bs_open)
			|| ((cw.op == stbs_pkg::OP_BS_CMP) && advance && hit);

		case (cw.cond)
			stbs_pkg::JC_ALWAYS:    cond = 1'b1;
			stbs_pkg::JC_SRCH_GO:   cond = in_fire && (req_type == stbs_pkg::REQ_SEARCH)
				&& (count_q != '0);
			stbs_pkg::JC_SORT_DONE: cond = i_done;
			stbs_pkg::JC_J_MORE:    cond = j_more;
			stbs_pkg::JC_BS_OPEN:   cond = bs_open;
			stbs_pkg::JC_HIT:       cond = hit;
			default:                cond = 1'b0;
		endcase
		pc_d = advance ? (cond ? cw.tgt_t : cw.tgt_f) : pc_q;

		rd_en = advance && (cw.rd != stbs_pkg::RD_NONE);
		unique case (cw.rd)
			stbs_pkg::RD_I:   rd_addr = i_q;
			stbs_pkg::RD_J:   rd_addr = j_q;
			stbs_pkg::RD_JN:  rd_addr = j_q + AW'(1);
			stbs_pkg::RD_MID: rd_addr = mid_c;
			default:          rd_addr = i_q;
		endcase

		wr_en   = 1'b0;
		wr_addr = i_q;
		wr_data = {hold_name_q, hold_key_q};
		unique case (cw.wr)
			stbs_pkg::WR_APPEND: begin
				wr_en   = in_fire && (req_type == stbs_pkg::REQ_APPEND) && !full;
				wr_addr = AW'(count_q);
				wr_data = {name_tag, number_key};
			end
			stbs_pkg::WR_SWAP: begin
				wr_en   = swap;
				wr_addr = j_q;
			end
			stbs_pkg::WR_I: wr_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= stbs_pkg::S_IDLE;
			count_q     <= '0;
			lo_q        <= '0;
			hip1_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
			mid_q       <= '0;
			key_q       <= '0;
			hold_key_q  <= '0;
			hold_name_q <= '0;
			out_valid_q <= 1'b0;
			status_q    <= stbs_pkg::ST_ADDED;
			fname_q     <= '0;
			fnum_q      <= '0;
		end else begin
			pc_q <= pc_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (cw.op)
				stbs_pkg::OP_ACCEPT: begin
					if (in_fire) begin
						key_q <= number_key;
						i_q   <= '0;
						if (req_type == stbs_pkg::REQ_APPEND) begin
							fname_q     <= '0;
							fnum_q      <= '0;
							if (full) begin
								status_q <= stbs_pkg::ST_FULL;
							end else begin
								status_q <= stbs_pkg::ST_ADDED;
								count_q  <= count_q + CW'(1);
							end
						end else if (count_q == '0) begin
							status_q    <= stbs_pkg::ST_EMPTY;
							fname_q     <= '0;
							fnum_q      <= '0;
						end
					end
				end
				stbs_pkg::OP_SORT_I: j_q <= i_q + AW'(1);
				stbs_pkg::OP_LOAD: begin
					hold_key_q  <= rd_key;
					hold_name_q <= rd_name;
				end
				stbs_pkg::OP_SORT_CMP: begin
					if (swap) begin
						hold_key_q  <= rd_key;
						hold_name_q <= rd_name;
					end
					j_q <= j_q + AW'(1);
				end
				stbs_pkg::OP_SORT_WB: i_q <= i_q + AW'(1);
				stbs_pkg::OP_BS_INIT: begin
					lo_q   <= '0;
					hip1_q <= count_q;
				end
				stbs_pkg::OP_BS_TEST: begin
					if (advance) begin
						mid_q <= mid_c;
						if (!bs_open) begin
							status_q    <= stbs_pkg::ST_MISS;
							fname_q     <= '0;
							fnum_q      <= '0;
						end
					end
				end
				stbs_pkg::OP_BS_CMP: begin
					if (advance) begin
						if (hit) begin
							status_q    <= stbs_pkg::ST_FOUND;
							fname_q     <= rd_name;
							fnum_q      <= rd_key;
						end else if (less) begin
							lo_q <= CW'(mid_q) + CW'(1);
						end else begin
							hip1_q <= CW'(mid_q);
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign found_name   = fname_q;
	assign found_number = fnum_q;

endmodule

// File: rtl/stbs_checker.sv
// ----------------------------------------------------------------------------
// stbs_checker: port-level checks for the sorted table block
// Watches the item channels only; bound to the top level below.
// ----------------------------------------------------------------------------
module stbs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          req_type,
	input logic [stbs_pkg::NAME_W-1:0]   name_tag,
	input logic [stbs_pkg::KEY_W-1:0]    number_key,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [stbs_pkg::STATUS_W-1:0] status,
	input logic [stbs_pkg::NAME_W-1:0]   found_name,
	input logic [stbs_pkg::KEY_W-1:0]    found_number
);

	logic in_fire;
	assign in_fire = in_valid && !in_stall;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(found_name) && $stable(found_number))
		else $error("stalled result changed");

	a_zero_on_nohit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != stbs_pkg::ST_FOUND) |->
			(found_name == '0) && (found_number == '0))
		else $error("payload not zero without a match");

	a_append_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (req_type == stbs_pkg::REQ_APPEND) |=>
			out_valid && ((status == stbs_pkg::ST_ADDED) || (status == stbs_pkg::ST_FULL)))
		else $error("append item gave no append result");

	a_search_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (req_type == stbs_pkg::REQ_SEARCH) |=>
			!out_valid || (status == stbs_pkg::ST_EMPTY))
		else $error("search item gave an early result");

endmodule

bind sorted_table_binary_search_top stbs_checker u_stbs_checker (.*);
